/* rtl/core/gif_literal_lzw_packer_core_defines.svh */
// Assertion macros for the packer's checker file.
`ifndef GIF_LITERAL_LZW_PACKER_CORE_DEFINES_SVH
`define GIF_LITERAL_LZW_PACKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GLP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("packer port check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GLP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("packer port check failed");

`endif

/* rtl/core/glp_pkg.sv */
// Types and constants shared by the GIF literal LZW packer modules.
package glp_pkg;

  localparam logic [7:0]  MIN_CODE_SIZE     = 8'd8;
  localparam logic [8:0]  CLEAR_CODE        = 9'd256;
  localparam logic [8:0]  EOI_CODE          = 9'd257;
  localparam logic [7:0]  CLEAR_INTERVAL    = 8'd254;
  localparam logic [7:0]  MAX_BLOCK         = 8'd255;
  localparam logic [4:0]  CODE_BITS         = 5'd9;
  localparam logic [4:0]  BYTE_BITS         = 5'd8;
  localparam logic [15:0] RESET_PIXEL_COUNT = 16'd256;

  // One classified pixel handed from the front end to the packer.
  typedef struct packed {
    logic [7:0]  pix;
    logic        first;        // first pixel of a frame
    logic        clr;          // a clear code follows this pixel
    logic        last;         // last pixel of the frame
    logic [16:0] frame_bytes;  // data bytes of the whole frame
  } cmd_t;

  // One byte of the output stream with its flags.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       eof;
  } obyte_t;

endpackage

/* rtl/core/glp_front.sv */
// Front end: pixel count register, frame length precalculation and pixel classification.
module glp_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  logic [7:0]     in_pixel_index,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [15:0]    cfg_pixel_count,
  input  logic           q_full,
  output logic           q_push,
  output glp_pkg::cmd_t  q_cmd
);

  typedef enum logic [3:0] {
    CALC_IDLE = 4'b0001,
    CALC_EST  = 4'b0010,
    CALC_FIX  = 4'b0100,
    CALC_SUM  = 4'b1000
  } calc_state_t;

  calc_state_t calc_r, calc_nxt;
  logic        started_r, started_nxt;
  logic [15:0] seen_r, seen_nxt;
  logic [7:0]  csc_r, csc_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [8:0]  quo_r, quo_nxt;
  logic [16:0] fbytes_r, fbytes_nxt;

  logic        accept;
  logic [15:0] seen_inc;
  logic [7:0]  csc_inc;
  logic        clr_now;
  logic        last_now;
  logic [24:0] est_prod;
  logic [17:0] rem;
  logic [16:0] codes;
  logic [20:0] bits_tot;

  assign cfg_ready = (calc_r == CALC_IDLE);
  assign full      = q_full || (calc_r != CALC_IDLE);
  assign accept    = push && !full;

  assign seen_inc = (started_r ? seen_r : 16'd0) + 16'd1;
  assign csc_inc  = (started_r ? csc_r : 8'd0) + 8'd1;
  assign clr_now  = (csc_inc >= glp_pkg::CLEAR_INTERVAL);
  assign last_now = (seen_inc >= cnt_r);

  assign q_push            = accept;
  assign q_cmd.pix         = in_pixel_index;
  assign q_cmd.first       = !started_r;
  assign q_cmd.clr         = clr_now;
  assign q_cmd.last        = last_now;
  assign q_cmd.frame_bytes = fbytes_r;

  // count/254 is estimated as count*258/65536, which is low by at most one.
  assign est_prod = {1'b0, cnt_r, 8'd0} + {8'd0, cnt_r, 1'b0};
  assign rem      = {2'd0, cnt_r} + {8'd0, quo_r, 1'b0} - {1'b0, quo_r, 8'd0};
  assign codes    = {1'b0, cnt_r} + {8'd0, quo_r} + 17'd2;
  assign bits_tot = {1'b0, codes, 3'd0} + {4'd0, codes} + 21'd7;

  always_comb begin
    calc_nxt    = calc_r;
    started_nxt = started_r;
    seen_nxt    = seen_r;
    csc_nxt     = csc_r;
    cnt_nxt     = cnt_r;
    quo_nxt     = quo_r;
    fbytes_nxt  = fbytes_r;
    unique case (calc_r)
      CALC_IDLE: begin
        if (cfg_valid && !started_r) begin
          cnt_nxt  = (cfg_pixel_count == 16'd0) ? 16'd1 : cfg_pixel_count;
          calc_nxt = CALC_EST;
        end
      end
      CALC_EST: begin
        quo_nxt  = est_prod[24:16];
        calc_nxt = CALC_FIX;
      end
      CALC_FIX: begin
        if (rem >= {10'd0, glp_pkg::CLEAR_INTERVAL}) begin
          quo_nxt = quo_r + 9'd1;
        end
        calc_nxt = CALC_SUM;
      end
      CALC_SUM: begin
        fbytes_nxt = bits_tot[19:3];
        calc_nxt   = CALC_IDLE;
      end
      default: calc_nxt = CALC_IDLE;
    endcase
    if (accept) begin
      if (last_now) begin
        started_nxt = 1'b0;
        seen_nxt    = 16'd0;
        csc_nxt     = 8'd0;
      end else begin
        started_nxt = 1'b1;
        seen_nxt    = seen_inc;
        csc_nxt     = clr_now ? 8'd0 : csc_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calc_r    <= CALC_EST;
      started_r <= 1'b0;
      seen_r    <= 16'd0;
      csc_r     <= 8'd0;
      cnt_r     <= glp_pkg::RESET_PIXEL_COUNT;
      quo_r     <= 9'd0;
      fbytes_r  <= 17'd0;
    end else begin
      calc_r    <= calc_nxt;
      started_r <= started_nxt;
      seen_r    <= seen_nxt;
      csc_r     <= csc_nxt;
      cnt_r     <= cnt_nxt;
      quo_r     <= quo_nxt;
      fbytes_r  <= fbytes_nxt;
    end
  end

endmodule

/* rtl/core/glp_cmd_queue.sv */
// Small command queue between the front end and the packer.
module glp_cmd_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  glp_pkg::cmd_t  wr_cmd,
  output logic           q_full,
  input  logic           rd_en,
  output logic           rd_valid,
  output glp_pkg::cmd_t  rd_cmd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  glp_pkg::cmd_t mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign q_full   = (cnt_r == FULL_CNT);
  assign rd_valid = (cnt_r != '0);
  assign rd_cmd   = mem_r[rp_r];
  assign do_wr    = wr_en && !q_full;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == LAST_PTR) ? '0 : wp_r + PW'(1);
    end
    if (do_rd) begin
      rp_nxt = (rp_r == LAST_PTR) ? '0 : rp_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/core/glp_back.sv */
// Back end: packs 9-bit codes into bytes, inserts sub-block lengths, queues output bytes.
module glp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  glp_pkg::cmd_t  q_cmd,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     out_byte,
  output logic           out_last_of_item,
  output logic           out_end_of_frame
);

  // Code slots: clear before the pixel, the pixel, clear after, end of information.
  logic        busy_r, busy_nxt;
  logic        mcs_r, mcs_nxt;
  logic [3:0]  codes_r, codes_nxt;
  logic        flush_r, flush_nxt;
  logic        term_r, term_nxt;
  logic [7:0]  pix_r, pix_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [4:0]  bits_r, bits_nxt;
  logic [7:0]  blk_r, blk_nxt;
  logic [16:0] strm_r, strm_nxt;

  logic        mcs_a, flush_a, term_a;
  logic [3:0]  codes_a;
  logic [15:0] acc_a;
  logic [4:0]  bits_a;
  logic [7:0]  blk_a;
  logic [16:0] strm_a;

  logic [8:0]  code_val;
  logic        code_any;
  logic        have8, flush_go, data_go;
  logic [15:0] w;
  logic [4:0]  n;
  logic        fire, emit, done_a, fin;
  glp_pkg::obyte_t ob;

  // Two-entry output queue.
  glp_pkg::obyte_t omem_r [2];
  logic        owp_r, orp_r;
  logic [1:0]  ocnt_r;
  logic        o_full, o_rd;

  assign o_full = (ocnt_r == 2'd2);
  assign empty  = (ocnt_r == 2'd0);
  assign o_rd   = pop && !empty;
  assign out_byte         = omem_r[orp_r].data;
  assign out_last_of_item = omem_r[orp_r].last;
  assign out_end_of_frame = omem_r[orp_r].eof;

  assign code_any = |codes_r;
  assign have8    = (bits_r >= glp_pkg::BYTE_BITS);
  assign flush_go = flush_r && (bits_r != 5'd0);
  assign data_go  = !mcs_r && (have8 || code_any || flush_go);
  assign fire     = busy_r && !o_full;
  assign emit     = fire && (mcs_r || data_go || term_r);

  // The lowest pending slot is the next code to go out.
  always_comb begin
    if (codes_r[0]) begin
      code_val = glp_pkg::CLEAR_CODE;
    end else if (codes_r[1]) begin
      code_val = {1'b0, pix_r};
    end else if (codes_r[2]) begin
      code_val = glp_pkg::CLEAR_CODE;
    end else begin
      code_val = glp_pkg::EOI_CODE;
    end
  end

  always_comb begin
    mcs_a   = mcs_r;
    codes_a = codes_r;
    flush_a = flush_r;
    term_a  = term_r;
    acc_a   = acc_r;
    bits_a  = bits_r;
    blk_a   = blk_r;
    strm_a  = strm_r;
    w       = acc_r;
    n       = bits_r;
    ob      = '{data: 8'd0, last: 1'b0, eof: 1'b0};
    if (mcs_r) begin
      ob.data = glp_pkg::MIN_CODE_SIZE;
      mcs_a   = 1'b0;
    end else if (data_go) begin
      if (have8) begin
        w = acc_r;
        n = bits_r;
      end else if (code_any) begin
        w       = acc_r | ({7'd0, code_val} << bits_r[2:0]);
        n       = bits_r + glp_pkg::CODE_BITS;
        codes_a = codes_r & (codes_r - 4'd1);
      end else begin
        // Final partial byte of the frame, padded with zeros.
        w       = acc_r;
        n       = glp_pkg::BYTE_BITS;
        flush_a = 1'b0;
      end
      if (blk_r == 8'd0) begin
        // A new sub-block opens with its length; the data byte follows as the next output byte.
        ob.data = (strm_r > {9'd0, glp_pkg::MAX_BLOCK}) ? glp_pkg::MAX_BLOCK : strm_r[7:0];
        blk_a   = ob.data;
        acc_a   = w;
        bits_a  = n;
      end else begin
        ob.data = w[7:0];
        acc_a   = w >> 8;
        bits_a  = n - glp_pkg::BYTE_BITS;
        blk_a   = blk_r - 8'd1;
        strm_a  = strm_r - 17'd1;
      end
    end else if (term_r) begin
      ob.eof = 1'b1;
      term_a = 1'b0;
    end
    done_a  = !mcs_a && (codes_a == 4'd0) && (bits_a < glp_pkg::BYTE_BITS)
              && !(flush_a && (bits_a != 5'd0)) && !term_a;
    ob.last = done_a;
  end

  assign fin   = !busy_r || (fire && done_a);
  assign q_pop = fin && q_valid;

  always_comb begin
    busy_nxt  = busy_r;
    mcs_nxt   = mcs_r;
    codes_nxt = codes_r;
    flush_nxt = flush_r;
    term_nxt  = term_r;
    pix_nxt   = pix_r;
    acc_nxt   = acc_r;
    bits_nxt  = bits_r;
    blk_nxt   = blk_r;
    strm_nxt  = strm_r;
    if (fire) begin
      mcs_nxt   = mcs_a;
      codes_nxt = codes_a;
      flush_nxt = flush_a;
      term_nxt  = term_a;
      acc_nxt   = acc_a;
      bits_nxt  = bits_a;
      blk_nxt   = blk_a;
      strm_nxt  = strm_a;
    end
    if (fin) begin
      busy_nxt = q_valid;
      if (q_valid) begin
        mcs_nxt   = q_cmd.first;
        codes_nxt = {q_cmd.last, q_cmd.clr, 1'b1, q_cmd.first};
        flush_nxt = q_cmd.last;
        term_nxt  = q_cmd.last;
        pix_nxt   = q_cmd.pix;
        if (q_cmd.first) begin
          acc_nxt  = 16'd0;
          bits_nxt = 5'd0;
          blk_nxt  = 8'd0;
          strm_nxt = q_cmd.frame_bytes;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      mcs_r   <= 1'b0;
      codes_r <= 4'd0;
      flush_r <= 1'b0;
      term_r  <= 1'b0;
      acc_r   <= 16'd0;
      bits_r  <= 5'd0;
      blk_r   <= 8'd0;
      strm_r  <= 17'd0;
    end else begin
      busy_r  <= busy_nxt;
      mcs_r   <= mcs_nxt;
      codes_r <= codes_nxt;
      flush_r <= flush_nxt;
      term_r  <= term_nxt;
      acc_r   <= acc_nxt;
      bits_r  <= bits_nxt;
      blk_r   <= blk_nxt;
      strm_r  <= strm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r <= pix_nxt;
    if (emit) begin
      omem_r[owp_r] <= ob;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (emit) begin
        owp_r <= !owp_r;
      end
      if (o_rd) begin
        orp_r <= !orp_r;
      end
      if (emit && !o_rd) begin
        ocnt_r <= ocnt_r + 2'd1;
      end else if (o_rd && !emit) begin
        ocnt_r <= ocnt_r - 2'd1;
      end
    end
  end

endmodule

/* rtl/core/gif_literal_lzw_packer_core.sv */
// Top level of the GIF literal LZW packer: front end, command queue and byte packer.
// This block turns one 8-bit palette index per pixel into GIF image data bytes, sending
// every pixel as a 9-bit literal code with the LZW framing and sub-block lengths the
// format needs. Pixels go in through a queue-style port (push/full) and bytes come out of
// one (empty/pop), each byte tagged with last_of_item and end_of_frame. The packer sends
// one byte per clock while its output queue has room; each 9-bit code is a little over
// one byte, and the first and last pixels of a frame also carry the framing bytes and
// codes of the frame's start and end. A pixel can be pushed every cycle while the command queue,
// CMD_DEPTH entries deep, has room. After reset and after each accepted pixel count write
// the front end works out the frame's byte count in its estimate, fix and sum states;
// during that time ready and the pixel input are held off.
module gif_literal_lzw_packer_core #(
  parameter int CMD_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_pixel_index,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_last_of_item,
  output logic        out_end_of_frame,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_pixel_count
);

  logic          q_full, q_push, q_pop, q_valid;
  glp_pkg::cmd_t wr_cmd, rd_cmd;

  glp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_pixel_index  (in_pixel_index),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_pixel_count (cfg_pixel_count),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (wr_cmd)
  );

  glp_cmd_queue #(
    .DEPTH (CMD_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_push),
    .wr_cmd   (wr_cmd),
    .q_full   (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_cmd   (rd_cmd)
  );

  glp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_cmd            (rd_cmd),
    .q_pop            (q_pop),
    .empty            (empty),
    .pop              (pop),
    .out_byte         (out_byte),
    .out_last_of_item (out_last_of_item),
    .out_end_of_frame (out_end_of_frame)
  );

endmodule

/* rtl/core/glp_checker.sv */
// Port-level checker for the GIF literal LZW packer, bound to the top level.
`include "gif_literal_lzw_packer_core_defines.svh"

module glp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        push,
  input logic        full,
  input logic [7:0]  in_pixel_index,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  out_byte,
  input logic        out_last_of_item,
  input logic        out_end_of_frame,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [15:0] cfg_pixel_count
);

  // While the frame length is being recalculated no pixel may enter.
  `GLP_ASSERT_IMP(a_calc_blocks_input, clk, rst_n, !cfg_ready, full)

  // The frame terminator is always the last byte of its pixel's transaction.
  `GLP_ASSERT_IMP(a_eof_is_last, clk, rst_n, !empty && out_end_of_frame, out_last_of_item)

  // The frame terminator is a zero-length block.
  `GLP_ASSERT_IMP(a_eof_is_zero, clk, rst_n, !empty && out_end_of_frame, out_byte == 8'd0)

  // A waiting byte stays put until it is popped.
  `GLP_ASSERT_NXT(a_out_holds, clk, rst_n, !empty && !pop,
                  !empty && $stable(out_byte) && $stable(out_end_of_frame))

endmodule

bind gif_literal_lzw_packer_core glp_checker u_glp_checker (.*);
